@@ src/text_console_glyph_blitter_macros.svh @@
// Assertion macros used by the text console blitter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_GLYPH_BLITTER_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_BLITTER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define TCG_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ src/tcg_pkg.sv @@
// Shared types and constants of the text console blitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcg_pkg;

    localparam int GLYPH_WIDTH  = 6;
    localparam int GLYPH_STRIDE = 16;
    localparam int FONT_AW      = 12;
    localparam int FONT_DEPTH   = 4096;

    localparam logic [7:0] PIX_MASK     = 8'hFC;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [2:0] {
        REQ_FONT   = 3'd0,
        REQ_PUT    = 3'd1,
        REQ_GOTO   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_CUR_ON = 3'd4,
        REQ_CUR_OFF= 3'd5,
        REQ_READ   = 3'd6
    } t_req;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_P_RD,
        S_P_WR0,
        S_P_WR1,
        S_SC_RD,
        S_SC_WR,
        S_RD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [FONT_AW-1:0] raddr;
    } t_font_acc;

endpackage

`default_nettype wire

@@ src/tcg_font_ram.sv @@
// Font store: 256 characters by 16 row bytes, one write and one registered read.
// Depends on tcg_pkg.
`default_nettype none

module tcg_font_ram (
    input  wire                 i_clk,
    input  wire tcg_pkg::t_font_acc i_acc,
    output logic [7:0]          o_rdata
);
    import tcg_pkg::*;

    logic [7:0] mem [FONT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_acc.we) begin
            mem[i_acc.waddr] <= i_acc.wdata;
        end
        o_rdata <= mem[i_acc.raddr];
    end

endmodule

`default_nettype wire

@@ src/tcg_pix_ram.sv @@
// Framebuffer store: one write port and one registered read port.
// Depends on tcg_pkg only for the common import convention.
`default_nettype none

module tcg_pix_ram #(
    parameter int DEPTH = 38400,
    parameter int AW    = 16
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [AW-1:0]    i_waddr,
    input  wire  [7:0]       i_wdata,
    input  wire  [AW-1:0]    i_raddr,
    output logic [7:0]       o_rdata
);
    import tcg_pkg::*;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/tcg_ctrl.sv @@
// Request sequencer: cursor state, glyph read-modify-write, scroll and clear sweeps.
// Depends on tcg_pkg and text_console_glyph_blitter_macros.svh.
`default_nettype none
`include "text_console_glyph_blitter_macros.svh"

module tcg_ctrl #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int GLYPH_HEIGHT  = 13,
    parameter int LINE_BYTES    = SCREEN_WIDTH / 8,
    parameter int STORE_BYTES   = LINE_BYTES * SCREEN_HEIGHT,
    parameter int PAW           = $clog2(STORE_BYTES)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [2:0]          i_req_type,
    input  wire  [7:0]          i_char_code,
    input  wire  [3:0]          i_glyph_row,
    input  wire  [7:0]          i_glyph_bits,
    input  wire  [6:0]          i_target_column,
    input  wire  [5:0]          i_target_row,
    input  wire  [15:0]         i_pixel_byte_addr,
    output logic                o_valid,
    output logic [7:0]          o_read_data,
    output logic [6:0]          o_cursor_column,
    output logic [5:0]          o_cursor_row,
    output logic                o_cursor_visible,
    output logic                o_pix_we,
    output logic [PAW-1:0]      o_pix_waddr,
    output logic [7:0]          o_pix_wdata,
    output logic [PAW-1:0]      o_pix_raddr,
    input  wire  [7:0]          i_pix_rdata,
    output tcg_pkg::t_font_acc  o_font,
    input  wire  [7:0]          i_font_rdata
);
    import tcg_pkg::*;

    localparam int TEXT_COLS       = SCREEN_WIDTH / GLYPH_WIDTH;
    localparam int TEXT_ROWS       = SCREEN_HEIGHT / GLYPH_HEIGHT;
    localparam int TEXT_LINE_BYTES = LINE_BYTES * GLYPH_HEIGHT;
    localparam int MOVED           = TEXT_LINE_BYTES * (TEXT_ROWS - 1);
    localparam int CW              = $clog2(TEXT_COLS);
    localparam int RW              = $clog2(TEXT_ROWS);
    localparam int XAW             = PAW + 1;

    t_state          r_state, n_state;
    logic [2:0]      r_req;
    logic [7:0]      r_code;
    logic [3:0]      r_grow;
    logic [7:0]      r_gbits;
    logic [6:0]      r_tcol;
    logic [5:0]      r_trow;
    logic [15:0]     r_paddr;
    logic            r_rd_ok;
    logic [7:0]      r_rdata;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_flag;
    logic [PAW-1:0]  r_ptr;
    logic            r_report;
    logic [XAW-1:0]  r_addr;
    logic [2:0]      r_sh;
    logic [3:0]      r_k;
    logic            r_toggle;
    logic [7:0]      r_g;

    logic            col_last, row_last, row_end, paint_end, newline;
    logic [CW+2:0]   col_px;
    logic [XAW-1:0]  base, addr1;
    logic [7:0]      g_now, sft0, byte0, byte1;
    logic [3:0]      up;

    assign col_last  = (r_col == CW'(TEXT_COLS - 1));
    assign row_last  = (r_row == RW'(TEXT_ROWS - 1));
    assign newline   = (r_code == NEWLINE_CODE);
    assign row_end   = ((r_state == S_P_WR0) && (r_sh <= 3'd2)) || (r_state == S_P_WR1);
    assign paint_end = row_end && (r_k == 4'(GLYPH_HEIGHT - 1));
    assign col_px    = (CW+3)'(r_col) * (CW+3)'(GLYPH_WIDTH);
    assign base      = XAW'(col_px >> 3) + XAW'(r_row) * XAW'(TEXT_LINE_BYTES);
    assign addr1     = r_addr + XAW'(1);

    // Merge of one glyph row into the one or two bytes that it straddles.
    assign g_now = r_toggle ? PIX_MASK : (i_font_rdata & PIX_MASK);
    assign sft0  = g_now >> r_sh;
    assign byte0 = r_toggle ? (i_pix_rdata ^ sft0)
                            : ((i_pix_rdata & ~(PIX_MASK >> r_sh)) | sft0);
    assign up    = 4'd8 - {1'b0, r_sh};
    assign byte1 = r_toggle ? (i_pix_rdata ^ (r_g << up))
                            : ((i_pix_rdata & ~(PIX_MASK << up)) | (r_g << up));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_ptr == PAW'(STORE_BYTES - 1)) begin
                    n_state = r_report ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (t_req'(r_req))
                    REQ_PUT: begin
                        if (!newline)      n_state = S_P_RD;
                        else if (row_last) n_state = S_SC_RD;
                        else               n_state = S_DONE;
                    end
                    REQ_CLEAR:   n_state = S_CLR;
                    REQ_CUR_ON:  n_state = r_flag ? S_DONE : S_P_RD;
                    REQ_CUR_OFF: n_state = r_flag ? S_P_RD : S_DONE;
                    REQ_READ:    n_state = S_RD_WAIT;
                    default:     n_state = S_DONE;
                endcase
            end
            S_P_RD:  n_state = S_P_WR0;
            S_P_WR0, S_P_WR1: begin
                if (r_state == S_P_WR0 && r_sh > 3'd2) begin
                    n_state = S_P_WR1;
                end else if (!paint_end) begin
                    n_state = S_P_RD;
                end else if (!r_toggle && col_last && row_last) begin
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SC_RD: n_state = S_SC_WR;
            S_SC_WR: n_state = (r_ptr == PAW'(MOVED - 1)) ? S_CLR : S_SC_RD;
            S_RD_WAIT: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pix_we     = 1'b0;
        o_pix_waddr  = r_ptr;
        o_pix_wdata  = 8'd0;
        o_pix_raddr  = r_addr[PAW-1:0];
        o_font.we    = 1'b0;
        o_font.waddr = {r_code, r_grow};
        o_font.wdata = r_gbits;
        o_font.raddr = {r_code, r_k};
        unique case (r_state)
            S_CLR: begin
                o_pix_we = 1'b1;
            end
            S_DISPATCH: begin
                o_pix_raddr = PAW'(r_paddr);
                o_font.we   = (t_req'(r_req) == REQ_FONT);
            end
            S_P_WR0: begin
                o_pix_we    = (r_addr < XAW'(STORE_BYTES));
                o_pix_waddr = r_addr[PAW-1:0];
                o_pix_wdata = byte0;
                o_pix_raddr = addr1[PAW-1:0];
            end
            S_P_WR1: begin
                o_pix_we    = (addr1 < XAW'(STORE_BYTES));
                o_pix_waddr = addr1[PAW-1:0];
                o_pix_wdata = byte1;
            end
            S_SC_RD: begin
                o_pix_raddr = r_ptr + PAW'(TEXT_LINE_BYTES);
            end
            S_SC_WR: begin
                o_pix_we    = 1'b1;
                o_pix_wdata = i_pix_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_col    <= '0;
            r_row    <= '0;
            r_flag   <= 1'b0;
            r_ptr    <= '0;
            r_report <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLR: begin
                    r_ptr <= r_ptr + PAW'(1);
                end
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req_type;
                        r_code  <= i_char_code;
                        r_grow  <= i_glyph_row;
                        r_gbits <= i_glyph_bits;
                        r_tcol  <= i_target_column;
                        r_trow  <= i_target_row;
                        r_paddr <= i_pixel_byte_addr;
                    end
                end
                S_DISPATCH: begin
                    r_rdata  <= 8'd0;
                    r_rd_ok  <= (32'(r_paddr) < 32'(STORE_BYTES));
                    r_addr   <= base;
                    r_sh     <= col_px[2:0];
                    r_k      <= 4'd0;
                    r_toggle <= (t_req'(r_req) == REQ_CUR_ON) || (t_req'(r_req) == REQ_CUR_OFF);
                    unique case (t_req'(r_req))
                        REQ_GOTO: begin
                            r_col <= (32'(r_tcol) < TEXT_COLS) ? CW'(r_tcol)
                                                                : CW'(TEXT_COLS - 1);
                            r_row <= (32'(r_trow) < TEXT_ROWS) ? RW'(r_trow)
                                                                : RW'(TEXT_ROWS - 1);
                        end
                        REQ_CLEAR: begin
                            r_col    <= '0;
                            r_row    <= '0;
                            r_flag   <= 1'b0;
                            r_ptr    <= '0;
                            r_report <= 1'b1;
                        end
                        REQ_PUT: begin
                            if (newline) begin
                                r_col <= '0;
                                if (row_last) r_ptr <= '0;
                                else          r_row <= r_row + RW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_P_WR0, S_P_WR1: begin
                    if (r_state == S_P_WR0) begin
                        r_g <= g_now;
                    end
                    if (row_end) begin
                        r_k    <= r_k + 4'd1;
                        r_addr <= r_addr + XAW'(LINE_BYTES);
                    end
                    if (paint_end) begin
                        if (r_toggle) begin
                            r_flag <= ~r_flag;
                        end else if (col_last) begin
                            r_col <= '0;
                            if (row_last) r_ptr <= '0;
                            else          r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                S_SC_WR: begin
                    r_ptr <= r_ptr + PAW'(1);
                    if (r_ptr == PAW'(MOVED - 1)) begin
                        r_report <= 1'b1;
                    end
                end
                S_RD_WAIT: begin
                    r_rdata <= r_rd_ok ? i_pix_rdata : 8'd0;
                end
                S_DONE: begin
                    r_report <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_DONE);
    assign o_read_data      = r_rdata;
    assign o_cursor_column  = 7'(r_col);
    assign o_cursor_row     = 6'(r_row);
    assign o_cursor_visible = r_flag;

    `TCG_ASSERT(a_strobe_single, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `TCG_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
    `TCG_NEVER(a_pix_range, o_pix_we && (32'(o_pix_waddr) >= 32'(STORE_BYTES)), "pixel write past store")
    `TCG_NEVER(a_row_range, 32'(r_row) >= 32'(TEXT_ROWS), "cursor row past last text row")

endmodule

`default_nettype wire

@@ src/text_console_glyph_blitter.sv @@
// Top level of the text console blitter: sequencer, framebuffer store and font store.
// Depends on tcg_pkg, tcg_ctrl, tcg_pix_ram and tcg_font_ram.
//
// Channel   | Handshake                 | Ports
// ----------+---------------------------+-------------------------------------------
// request   | start high while !busy    | i_req_type .. i_pixel_byte_addr
// result    | o_valid, one cycle        | o_read_data, o_cursor_column/row/visible
//
// Each request yields exactly one result. Simple requests (font write, goto, read,
// cursor toggle that changes nothing) go from dispatch to the result, a read by way
// of a wait state. A character or cursor toggle does one read-modify-write per glyph
// row through the framebuffer store, with a second write when the glyph straddles a
// byte. A scroll copies the store byte by byte, a read then a write per moved byte,
// and then zeroes everything below the moved part one byte a cycle; a clear zeroes
// the whole store one byte a cycle. After reset the same zeroing pass runs over all
// SCREEN_WIDTH/8*SCREEN_HEIGHT store bytes with busy high and no result.
// The result side cannot stall; a result is presented in a cycle of its own.
`default_nettype none

module text_console_glyph_blitter #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int GLYPH_HEIGHT  = 13
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire  [2:0]   i_req_type,
    input  wire  [7:0]   i_char_code,
    input  wire  [3:0]   i_glyph_row,
    input  wire  [7:0]   i_glyph_bits,
    input  wire  [6:0]   i_target_column,
    input  wire  [5:0]   i_target_row,
    input  wire  [15:0]  i_pixel_byte_addr,
    output logic         o_valid,
    output logic [7:0]   o_read_data,
    output logic [6:0]   o_cursor_column,
    output logic [5:0]   o_cursor_row,
    output logic         o_cursor_visible
);
    import tcg_pkg::*;

    localparam int LINE_BYTES  = SCREEN_WIDTH / 8;
    localparam int STORE_BYTES = LINE_BYTES * SCREEN_HEIGHT;
    localparam int PAW         = $clog2(STORE_BYTES);

    logic            pix_we;
    logic [PAW-1:0]  pix_waddr;
    logic [7:0]      pix_wdata;
    logic [PAW-1:0]  pix_raddr;
    logic [7:0]      pix_rdata;
    t_font_acc       font_acc;
    logic [7:0]      font_rdata;

    // The sequencer owns all cursor state and drives both store ports.
    tcg_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_HEIGHT  (GLYPH_HEIGHT),
        .LINE_BYTES    (LINE_BYTES),
        .STORE_BYTES   (STORE_BYTES),
        .PAW           (PAW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_char_code       (i_char_code),
        .i_glyph_row       (i_glyph_row),
        .i_glyph_bits      (i_glyph_bits),
        .i_target_column   (i_target_column),
        .i_target_row      (i_target_row),
        .i_pixel_byte_addr (i_pixel_byte_addr),
        .o_valid           (o_valid),
        .o_read_data       (o_read_data),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_visible  (o_cursor_visible),
        .o_pix_we          (pix_we),
        .o_pix_waddr       (pix_waddr),
        .o_pix_wdata       (pix_wdata),
        .o_pix_raddr       (pix_raddr),
        .i_pix_rdata       (pix_rdata),
        .o_font            (font_acc),
        .i_font_rdata      (font_rdata)
    );

    // Framebuffer bytes, eight pixels each with the leftmost pixel in the msb.
    tcg_pix_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (PAW)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    // Font rows; entries hold whatever was last loaded and are not cleared.
    tcg_font_ram u_font_ram (
        .i_clk   (i_clk),
        .i_acc   (font_acc),
        .o_rdata (font_rdata)
    );

endmodule

`default_nettype wire

@@ bench/tb_text_console_glyph_blitter.sv @@
// Self-checking testbench of the text console glyph blitter: directed and random requests.
// Depends on tcg_pkg and text_console_glyph_blitter; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_text_console_glyph_blitter;
    import tcg_pkg::*;

    // Geometry of the default build.
    localparam int LINE_BYTES  = 80;
    localparam int STORE_BYTES = 38400;
    localparam int TEXT_COLS   = 106;
    localparam int TEXT_ROWS   = 36;
    localparam int GLYPH_H     = 13;
    localparam int TLINE_BYTES = LINE_BYTES * GLYPH_H;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Scrolls and clears are slow, so the random part spends only a few of each.
    localparam int SCROLL_BUDGET = 5;
    localparam int CLEAR_BUDGET  = 3;
    localparam int RANDOM_ITEMS  = 1830;

    // Console predictor with its own framebuffer, font and cursor state, plus the
    // queue of expected results and the mismatch bookkeeping.
    class console_scoreboard;
        logic [7:0]  pixels [STORE_BYTES];
        logic [7:0]  font [4096];
        int          col_pos;
        int          row_pos;
        bit          cur_drawn;
        int          scrolls;
        int          mismatches;
        int          checked;
        logic [21:0] pending [$];

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            foreach (font[i]) font[i] = 8'h00;
            col_pos = 0;
            row_pos = 0;
            cur_drawn = 0;
            scrolls = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void merge(int addr, logic [7:0] keep, logic [7:0] bits, bit toggle);
            if (addr >= STORE_BYTES) return;
            if (toggle) pixels[addr] = pixels[addr] ^ bits;
            else pixels[addr] = (pixels[addr] & keep) | bits;
        endfunction

        // Draws a glyph, or XORs the block cursor, at the cursor cell.
        function void paint(bit toggle, logic [7:0] code);
            int base;
            int sh;
            logic [7:0] g;
            int addr;
            base = (GLYPH_WIDTH * col_pos) / 8 + TLINE_BYTES * row_pos;
            sh = (col_pos * GLYPH_WIDTH) & 7;
            for (int k = 0; k < GLYPH_H; k++) begin
                g = toggle ? PIX_MASK : (font[code * GLYPH_STRIDE + k] & PIX_MASK);
                addr = base + k * LINE_BYTES;
                merge(addr, ~(PIX_MASK >> sh), g >> sh, toggle);
                if (sh > 2)
                    merge(addr + 1, ~(PIX_MASK << (8 - sh)), g << (8 - sh), toggle);
            end
        endfunction

        function void line_feed();
            col_pos = 0;
            row_pos++;
            if (row_pos >= TEXT_ROWS) begin
                row_pos = TEXT_ROWS - 1;
                scrolls++;
                for (int i = 0; i < STORE_BYTES; i++)
                    pixels[i] = (i + TLINE_BYTES < STORE_BYTES) ? pixels[i + TLINE_BYTES] : 8'h00;
            end
        endfunction

        // Applies one accepted request and queues the result it must produce.
        function void note_request(logic [2:0] req, logic [7:0] code, logic [3:0] grow,
                                   logic [7:0] gbits, logic [6:0] tcol, logic [5:0] trow,
                                   logic [15:0] addr);
            logic [7:0] rd;
            rd = 8'h00;
            case (req)
                REQ_FONT: font[{code, grow}] = gbits;
                REQ_PUT: begin
                    if (code == NEWLINE_CODE) line_feed();
                    else begin
                        paint(0, code);
                        col_pos++;
                        if (col_pos >= TEXT_COLS) line_feed();
                    end
                end
                REQ_GOTO: begin
                    col_pos = (tcol < TEXT_COLS) ? tcol : TEXT_COLS - 1;
                    row_pos = (trow < TEXT_ROWS) ? trow : TEXT_ROWS - 1;
                end
                REQ_CLEAR: begin
                    foreach (pixels[i]) pixels[i] = 8'h00;
                    col_pos = 0;
                    row_pos = 0;
                    cur_drawn = 0;
                end
                REQ_CUR_ON: if (!cur_drawn) begin
                    paint(1, 8'h00);
                    cur_drawn = 1;
                end
                REQ_CUR_OFF: if (cur_drawn) begin
                    paint(1, 8'h00);
                    cur_drawn = 0;
                end
                REQ_READ: rd = (addr < STORE_BYTES) ? pixels[addr] : 8'h00;
                default: ;
            endcase
            pending.push_back({rd, 7'(col_pos), 6'(row_pos), cur_drawn});
        endfunction

        // Compares one result with the oldest expectation.
        function void check_result(logic [7:0] rd, logic [6:0] c, logic [5:0] r, logic v);
            logic [21:0] exp_res;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing expected");
                return;
            end
            exp_res = pending.pop_front();
            if ({rd, c, r, v} !== exp_res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected data %h col %0d row %0d vis %0d, got data %h col %0d row %0d vis %0d",
                             checked, exp_res[21:14], exp_res[13:7], exp_res[6:1], exp_res[0],
                             rd, c, r, v);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [7:0]  i_char_code = '0;
    logic [3:0]  i_glyph_row = '0;
    logic [7:0]  i_glyph_bits = '0;
    logic [6:0]  i_target_column = '0;
    logic [5:0]  i_target_row = '0;
    logic [15:0] i_pixel_byte_addr = '0;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [6:0]  o_cursor_column;
    logic [5:0]  o_cursor_row;
    logic        o_cursor_visible;

    console_scoreboard sb = new();
    // Rows 0..12 written per character code; a code is drawable once all are.
    logic [12:0] font_rows [256];
    int clears_used = 0;
    int draws = 0;

    text_console_glyph_blitter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_char_code(i_char_code), .i_glyph_row(i_glyph_row),
        .i_glyph_bits(i_glyph_bits), .i_target_column(i_target_column),
        .i_target_row(i_target_row), .i_pixel_byte_addr(i_pixel_byte_addr),
        .o_valid(o_valid), .o_read_data(o_read_data), .o_cursor_column(o_cursor_column),
        .o_cursor_row(o_cursor_row), .o_cursor_visible(o_cursor_visible)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobed cycle is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_read_data, o_cursor_column, o_cursor_row, o_cursor_visible);
    end

    function automatic int idle_gap();
        if ($urandom_range(9) == 0) return $urandom_range(60, 15);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(3);
    endfunction

    // Presents one request and holds it until the block takes it. Start is lowered
    // only when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(logic [2:0] req, logic [7:0] code, logic [3:0] grow,
                                logic [7:0] gbits, logic [6:0] tcol, logic [5:0] trow,
                                logic [15:0] addr);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_char_code <= code;
        i_glyph_row <= grow;
        i_glyph_bits <= gbits;
        i_target_column <= tcol;
        i_target_row <= trow;
        i_pixel_byte_addr <= addr;
        do @(posedge i_clk); while (busy);
        sb.note_request(req, code, grow, gbits, tcol, trow, addr);
        if (req == REQ_FONT && grow < GLYPH_H) font_rows[code][grow] = 1'b1;
        if (req == REQ_PUT && code != NEWLINE_CODE) draws++;
    endtask

    task automatic send_simple(logic [2:0] req);
        send_request(req, 8'($urandom), 4'($urandom), 8'($urandom), 7'($urandom),
                     6'($urandom), 16'($urandom));
    endtask

    // Picks a drawable code, mostly from those already loaded.
    function automatic int pick_loaded();
        int tries;
        int c;
        for (tries = 0; tries < 40; tries++) begin
            c = $urandom_range(255);
            if (&font_rows[c]) return c;
        end
        for (c = 0; c < 256; c++) if (&font_rows[c]) return c;
        return -1;
    endfunction

    task automatic random_request();
        int pick;
        int c;
        int base;
        logic [15:0] addr;
        pick = $urandom_range(99);
        if (pick < 22) begin
            // Font loads concentrate on a few codes so they become drawable quickly.
            c = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15) * 17;
            send_request(REQ_FONT, 8'(c), 4'($urandom), 8'($urandom), 7'($urandom),
                         6'($urandom), 16'($urandom));
        end else if (pick < 65) begin
            c = ($urandom_range(9) == 0) ? NEWLINE_CODE : pick_loaded();
            if (c < 0) c = NEWLINE_CODE;
            if (c == NEWLINE_CODE && c != 10) c = NEWLINE_CODE;
            // At the bottom a line feed scrolls; past the budget move the cursor up.
            if (sb.row_pos == TEXT_ROWS - 1 && (c == NEWLINE_CODE || sb.col_pos == TEXT_COLS - 1)
                && sb.scrolls >= SCROLL_BUDGET)
                send_request(REQ_GOTO, 8'($urandom), 4'($urandom), 8'($urandom),
                             7'($urandom_range(TEXT_COLS - 1)), 6'($urandom_range(TEXT_ROWS - 2)),
                             16'($urandom));
            else
                send_request(REQ_PUT, 8'(c), 4'($urandom), 8'($urandom), 7'($urandom),
                             6'($urandom), 16'($urandom));
        end else if (pick < 75) begin
            if ($urandom_range(4) == 0) send_simple(REQ_GOTO);
            else
                send_request(REQ_GOTO, 8'($urandom), 4'($urandom), 8'($urandom),
                             7'($urandom_range(TEXT_COLS - 1)), 6'($urandom_range(TEXT_ROWS - 1)),
                             16'($urandom));
        end else if (pick < 90) begin
            base = (GLYPH_WIDTH * sb.col_pos) / 8 + TLINE_BYTES * sb.row_pos;
            case ($urandom_range(9))
                0: addr = 16'($urandom_range(65535, STORE_BYTES));
                1, 2: addr = 16'($urandom_range(STORE_BYTES - 1));
                default: addr = 16'(base + LINE_BYTES * $urandom_range(GLYPH_H - 1)
                                    + $urandom_range(1));
            endcase
            send_request(REQ_READ, 8'($urandom), 4'($urandom), 8'($urandom), 7'($urandom),
                         6'($urandom), addr);
        end else if (pick < 95) begin
            send_simple(REQ_CUR_ON);
        end else if (pick < 98) begin
            send_simple(REQ_CUR_OFF);
        end else if (pick < 99 && clears_used < CLEAR_BUDGET && $urandom_range(3) == 0) begin
            clears_used++;
            send_simple(REQ_CLEAR);
        end else begin
            send_simple(REQ_UNUSED);
        end
    endtask

    initial begin
        int wait_cycles;
        foreach (font_rows[i]) font_rows[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a full-extreme glyph at the top code, drawn where it straddles
        // a byte in the last column so it wraps, goto saturation, newline, the block cursor,
        // reads near the top, at the bottom and past the store, the unused code and a clear.
        for (int k = 0; k < GLYPH_H; k++)
            send_request(REQ_FONT, 8'hFF, 4'(k), (k % 2) ? 8'hFF : 8'hA9, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_GOTO, 8'h00, 4'hF, 8'h00, 7'd105, 6'd0, 16'hFFFF);
        send_request(REQ_PUT, 8'hFF, 4'h0, 8'h00, 7'h7F, 6'h3F, 16'h0000);
        send_request(REQ_READ, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'd79);
        send_request(REQ_GOTO, 8'h00, 4'h0, 8'h00, 7'h7F, 6'h3F, 16'h0000);
        send_request(REQ_PUT, NEWLINE_CODE, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_CUR_ON, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_CUR_ON, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_READ, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'd37440);
        send_request(REQ_CUR_OFF, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_READ, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'd38399);
        send_request(REQ_READ, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'hFFFF);
        send_request(REQ_UNUSED, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);
        send_request(REQ_CLEAR, 8'h00, 4'h0, 8'h00, 7'h00, 6'h00, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) random_request();
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);

        $display("Covered %0d results, %0d glyph draws, %0d scrolls and %0d random clears.",
                 sb.checked, draws, sb.scrolls, clears_used);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("** text_console_glyph_blitter: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results still expected.", sb.mismatches,
                     sb.pending.size());
            $display("** text_console_glyph_blitter: FAILED **");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("Timeout with %0d results still expected.", sb.pending.size());
        $display("** text_console_glyph_blitter: FAILED **");
        $finish;
    end

endmodule
